### src/hrbd_pkg.sv
// hrbd_pkg: shared types, codes and match tables of the response body deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hrbd_pkg;

  localparam int unsigned DefMaxLine  = 1024;
  localparam int unsigned DefBufBytes = 65536;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERR   = 2'd3
  } hrbd_kind_e;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_FIXED   = 4'd1,
    PH_SIZE    = 4'd2,
    PH_SIZE_LF = 4'd3,
    PH_DATA    = 4'd4,
    PH_TRAIL1  = 4'd5,
    PH_TRAIL2  = 4'd6,
    PH_END1    = 4'd7,
    PH_END2    = 4'd8
  } hrbd_phase_e;

  typedef struct packed {
    logic        vld;
    hrbd_kind_e  kind;
    logic [7:0]  body_byte;
    logic        last;
    logic [15:0] status_code;
    logic [16:0] body_length;
  } hrbd_res_t;

  function automatic logic [7:0] pfx_status(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "H";
      4'd1: c = "T";
      4'd2: c = "T";
      4'd3: c = "P";
      4'd4: c = "/";
      4'd5: c = "1";
      4'd6: c = ".";
      4'd7: c = "1";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pfx_enc(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0: c = "T";   5'd1: c = "r";   5'd2: c = "a";   5'd3: c = "n";
      5'd4: c = "s";   5'd5: c = "f";   5'd6: c = "e";   5'd7: c = "r";
      5'd8: c = "-";   5'd9: c = "E";   5'd10: c = "n";  5'd11: c = "c";
      5'd12: c = "o";  5'd13: c = "d";  5'd14: c = "i";  5'd15: c = "n";
      5'd16: c = "g";  5'd17: c = ":";
      // chunked token, offset by the prefix length
      5'd19: c = "h";  5'd20: c = "u";  5'd21: c = "n";  5'd22: c = "k";
      5'd23: c = "e";  5'd24: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pfx_len(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0: c = "C";   5'd1: c = "o";   5'd2: c = "n";   5'd3: c = "t";
      5'd4: c = "e";   5'd5: c = "n";   5'd6: c = "t";   5'd7: c = "-";
      5'd8: c = "L";   5'd9: c = "e";   5'd10: c = "n";  5'd11: c = "g";
      5'd12: c = "t";  5'd13: c = "h";  5'd14: c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage
`default_nettype wire

### src/hrbd_in_if.sv
// hrbd_in_if: input word channel of the deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface hrbd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       no_body;
  modport source (output valid, req_type, data_byte, no_body, input ready);
  modport sink (input valid, req_type, data_byte, no_body, output ready);
endinterface
`default_nettype wire

### src/hrbd_out_if.sv
// hrbd_out_if: result word channel of the deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface hrbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  body_byte;
  logic        last;
  logic [15:0] status_code;
  logic [16:0] body_length;
  modport source (output valid, out_kind, body_byte, last, status_code, body_length,
                  input ready);
  modport sink (input valid, out_kind, body_byte, last, status_code, body_length,
                output ready);
endinterface
`default_nettype wire

### src/hrbd_core.sv
// hrbd_core: parser state and the per-word update logic
// depends on hrbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module hrbd_core #(
  parameter int unsigned MAX_LINE  = hrbd_pkg::DefMaxLine,
  parameter int unsigned BUF_BYTES = hrbd_pkg::DefBufBytes
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire                 req_type_i,
  input  wire  [7:0]          data_byte_i,
  input  wire                 no_body_i,
  output hrbd_pkg::hrbd_res_t res_o
);
  import hrbd_pkg::*;

  localparam logic [16:0] MaxLine  = 17'(MAX_LINE);
  localparam logic [16:0] BufBytes = 17'(BUF_BYTES);

  hrbd_phase_e phase_q, phase_d;
  logic [1:0]  crlf_q, crlf_d;
  logic [15:0] line_len_q, line_len_d;
  logic [3:0]  spos_q, spos_d;
  logic [4:0]  epos_q, epos_d;
  logic [4:0]  lpos_q, lpos_d;
  logic        f_stat_q, f_stat_d, f_enc_q, f_enc_d, f_chunk_q, f_chunk_d;
  logic        f_len_q, f_len_d, f_stop_q, f_stop_d;
  logic [15:0] sv_q, sv_d;
  logic [31:0] cl_q, cl_d;
  logic [31:0] cr_q, cr_d;
  logic [3:0]  hc_q, hc_d;
  logic        head_q, head_d;
  logic [16:0] taken_q, taken_d;
  logic [16:0] bo_q, bo_d;

  logic        restart;
  logic [7:0]  b;
  logic [19:0] sv_ext;
  logic [35:0] cl_ext;
  logic        hex_ok;
  logic [3:0]  hex_v;

  assign b = data_byte_i;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (b >= "0" && b <= "9") hex_v = 4'(b - 8'h30);
    else if (b >= "a" && b <= "f") hex_v = 4'(b - 8'h57);
    else if (b >= "A" && b <= "F") hex_v = 4'(b - 8'h37);
    else hex_ok = 1'b0;
  end

  always_comb begin
    phase_d = phase_q; crlf_d = crlf_q; line_len_d = line_len_q;
    spos_d = spos_q; epos_d = epos_q; lpos_d = lpos_q;
    f_stat_d = f_stat_q; f_enc_d = f_enc_q; f_chunk_d = f_chunk_q;
    f_len_d = f_len_q; f_stop_d = f_stop_q;
    sv_d = sv_q; cl_d = cl_q; cr_d = cr_q; hc_d = hc_q;
    head_d = head_q; taken_d = taken_q; bo_d = bo_q;
    restart = 1'b0;
    res_o = '0;
    sv_ext = '0;
    cl_ext = '0;

    if (req_type_i) begin
      restart = 1'b1;
    end else if (taken_q >= BufBytes) begin
      res_o.vld = 1'b1; res_o.kind = KIND_ERR; res_o.last = 1'b1;
      restart = 1'b1;
    end else begin
      taken_d = taken_q + 17'd1;
      unique case (phase_q)
        PH_HEADER: begin
          if (!f_stop_q) begin
            if (b == ChLf) begin
              // end of a header line: settle fields that matched on it
              if ({1'b0, line_len_q} + 17'd1 >= MaxLine) begin
                f_stop_d = 1'b1;
                if (!f_stat_q) sv_d = '0;
                if (!f_len_q) cl_d = '0;
              end else begin
                if (!f_stat_q) begin
                  if (spos_q == 4'd9 || spos_q == 4'd10) f_stat_d = 1'b1;
                  else sv_d = '0;
                end
                if (!f_enc_q) begin
                  if (epos_q == 5'd25 || epos_q == 5'd27) begin
                    f_enc_d = 1'b1; f_chunk_d = 1'b1;
                  end else if ((epos_q >= 5'd19 && epos_q <= 5'd24) || epos_q == 5'd26) begin
                    f_enc_d = 1'b1;
                  end
                end
                if (!f_len_q) begin
                  if (lpos_q == 5'd16 || lpos_q == 5'd17) f_len_d = 1'b1;
                  else cl_d = '0;
                end
              end
              spos_d = '0; epos_d = '0; lpos_d = '0; line_len_d = '0;
            end else if (line_len_q == '0 && b == ChCr) begin
              f_stop_d = 1'b1;
            end else begin
              // status line matcher
              if (!f_stat_q) begin
                if (spos_q < 4'd8) begin
                  spos_d = (b == pfx_status(spos_q)) ? spos_q + 4'd1 : 4'd15;
                end else if (spos_q == 4'd8) begin
                  if (is_dig(b)) begin
                    sv_d = {12'd0, b[3:0]}; spos_d = 4'd9;
                  end else if (!is_ws(b)) spos_d = 4'd15;
                end else if (spos_q == 4'd9) begin
                  if (is_dig(b)) begin
                    sv_ext = {sv_q, 3'd0} + {3'd0, sv_q, 1'b0} + 20'(b[3:0]);
                    sv_d = (sv_ext > 20'hFFFF) ? 16'hFFFF : sv_ext[15:0];
                  end else spos_d = 4'd10;
                end
              end
              // transfer-encoding matcher
              if (!f_enc_q) begin
                if (epos_q < 5'd18) begin
                  epos_d = (b == pfx_enc(epos_q)) ? epos_q + 5'd1 : 5'd31;
                end else if (epos_q == 5'd18) begin
                  if (b == "c") epos_d = 5'd19;
                  else if (!is_ws(b)) epos_d = 5'd26;
                end else if (epos_q >= 5'd19 && epos_q <= 5'd24) begin
                  epos_d = (b == pfx_enc(epos_q)) ? epos_q + 5'd1 : 5'd26;
                end else if (epos_q == 5'd25) begin
                  epos_d = is_ws(b) ? 5'd27 : 5'd26;
                end
              end
              // content-length matcher
              if (!f_len_q) begin
                if (lpos_q < 5'd15) begin
                  lpos_d = (b == pfx_len(lpos_q)) ? lpos_q + 5'd1 : 5'd31;
                end else if (lpos_q == 5'd15) begin
                  if (is_dig(b)) begin
                    cl_d = {28'd0, b[3:0]}; lpos_d = 5'd16;
                  end else if (!is_ws(b)) lpos_d = 5'd31;
                end else if (lpos_q == 5'd16) begin
                  if (is_dig(b)) begin
                    cl_ext = {cl_q, 3'd0} + {3'd0, cl_q, 1'b0} + 36'(b[3:0]);
                    cl_d = (cl_ext > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : cl_ext[31:0];
                  end else lpos_d = 5'd17;
                end
              end
              if (line_len_q != 16'hFFFF) line_len_d = line_len_q + 16'd1;
            end
          end
          if (b == ChLf && crlf_q == 2'd3) begin
            // blank line: header done
            if (!f_stat_d) begin
              res_o.vld = 1'b1; res_o.kind = KIND_ERR; res_o.last = 1'b1;
              restart = 1'b1;
            end else if (head_q || (!f_chunk_d && cl_d == '0)) begin
              res_o.vld = 1'b1; res_o.kind = KIND_DONE; res_o.last = 1'b1;
              restart = 1'b1;
            end else if (f_chunk_d) begin
              phase_d = PH_SIZE; cr_d = '0; hc_d = '0;
            end else begin
              phase_d = PH_FIXED;
            end
          end else if (b == (crlf_q[0] ? ChLf : ChCr)) begin
            crlf_d = crlf_q + 2'd1;
          end else begin
            crlf_d = (b == ChCr) ? 2'd1 : 2'd0;
          end
        end
        PH_FIXED: begin
          bo_d = bo_q + 17'd1;
          res_o.vld = 1'b1; res_o.body_byte = b;
          if ({15'd0, bo_d} >= cl_q) begin
            res_o.kind = KIND_FINAL; res_o.last = 1'b1; restart = 1'b1;
          end else begin
            res_o.kind = KIND_BYTE;
          end
        end
        PH_SIZE: begin
          if (hex_ok && hc_q < 4'd8) begin
            cr_d = {cr_q[27:0], hex_v}; hc_d = hc_q + 4'd1;
          end else if (!hex_ok && b == ChCr && hc_q != '0) begin
            phase_d = PH_SIZE_LF;
          end else begin
            res_o.vld = 1'b1; res_o.kind = KIND_ERR; res_o.last = 1'b1;
            restart = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (b != ChLf) begin
            res_o.vld = 1'b1; res_o.kind = KIND_ERR; res_o.last = 1'b1;
            restart = 1'b1;
          end else begin
            phase_d = (cr_q == '0) ? PH_END1 : PH_DATA;
          end
        end
        PH_DATA: begin
          bo_d = bo_q + 17'd1;
          cr_d = cr_q - 32'd1;
          if (cr_d == '0) phase_d = PH_TRAIL1;
          res_o.vld = 1'b1; res_o.kind = KIND_BYTE; res_o.body_byte = b;
        end
        PH_TRAIL1: phase_d = PH_TRAIL2;
        PH_TRAIL2: begin
          phase_d = PH_SIZE; cr_d = '0; hc_d = '0;
        end
        PH_END1: phase_d = PH_END2;
        default: begin
          res_o.vld = 1'b1; res_o.kind = KIND_DONE; res_o.last = 1'b1;
          restart = 1'b1;
        end
      endcase
    end

    res_o.status_code = sv_d;
    res_o.body_length = bo_d;

    if (restart) begin
      phase_d = PH_HEADER; crlf_d = '0; line_len_d = '0;
      spos_d = '0; epos_d = '0; lpos_d = '0;
      f_stat_d = 1'b0; f_enc_d = 1'b0; f_chunk_d = 1'b0; f_len_d = 1'b0; f_stop_d = 1'b0;
      sv_d = '0; cl_d = '0; cr_d = '0; hc_d = '0;
      head_d = req_type_i & no_body_i;
      taken_d = '0; bo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; crlf_q <= '0; line_len_q <= '0;
      spos_q <= '0; epos_q <= '0; lpos_q <= '0;
      f_stat_q <= 1'b0; f_enc_q <= 1'b0; f_chunk_q <= 1'b0; f_len_q <= 1'b0;
      f_stop_q <= 1'b0;
      sv_q <= '0; cl_q <= '0; cr_q <= '0; hc_q <= '0;
      head_q <= 1'b0; taken_q <= '0; bo_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; crlf_q <= crlf_d; line_len_q <= line_len_d;
      spos_q <= spos_d; epos_q <= epos_d; lpos_q <= lpos_d;
      f_stat_q <= f_stat_d; f_enc_q <= f_enc_d; f_chunk_q <= f_chunk_d;
      f_len_q <= f_len_d; f_stop_q <= f_stop_d;
      sv_q <= sv_d; cl_q <= cl_d; cr_q <= cr_d; hc_q <= hc_d;
      head_q <= head_d; taken_q <= taken_d; bo_q <= bo_d;
    end
  end

  a_chunk_needs_enc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_chunk_q |-> f_enc_q) else $error("chunked flag without encoding flag");
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cr_q != '0)) else $error("data phase with empty chunk");
  a_hex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= 4'd8) else $error("hex digit count overran");

endmodule
`default_nettype wire

### src/http_response_body_deframer_top.sv
// http_response_body_deframer_top: input register, parser core and result register
// depends on hrbd_pkg, hrbd_in_if, hrbd_out_if, hrbd_core
`timescale 1ns / 1ps
`default_nettype none
// usage
// - in_i carries one word per handshake: a response byte (req_type 0) or a
//   start marker (req_type 1) whose no_body bit flags a reply to HEAD
// - out_o carries at most one result word per input word: body bytes, the
//   final byte, a completion or an error; last marks the end of a response
// - a start marker drops any response in progress silently
// - a word lands in the input register; the parser runs on it and loads
//   the result register, which drives out_o, once that register is free
// - throughput: one word per cycle while out_o does not stall; the parser
//   update between the input register and the result register is combinational
// - when out_o stalls with a result held, the parsed word waits in the input
//   register and in_i.ready drops; a word that gives no result still needs
//   the result register free before it moves on
// - reset clears both registers' valid bits and all parser state, leaving the
//   parser in the header phase waiting for a status line
module http_response_body_deframer_top #(
  parameter int unsigned MAX_LINE  = hrbd_pkg::DefMaxLine,
  parameter int unsigned BUF_BYTES = hrbd_pkg::DefBufBytes
) (
  input wire         clk_i,
  input wire         rst_ni,
  hrbd_in_if.sink    in_i,
  hrbd_out_if.source out_o
);
  import hrbd_pkg::*;

  // input register
  logic       in_vld_q;
  logic       req_q;
  logic [7:0] byte_q;
  logic       nob_q;

  // result register
  logic       out_vld_q;
  hrbd_res_t  out_q;
  hrbd_res_t  res;

  logic advance;

  // parse when a word is held and the result register can take its result
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q  <= in_i.req_type;
      byte_q <= in_i.data_byte;
      nob_q  <= in_i.no_body;
    end
  end

  hrbd_core #(
    .MAX_LINE  (MAX_LINE),
    .BUF_BYTES (BUF_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_type_i  (req_q),
    .data_byte_i (byte_q),
    .no_body_i   (nob_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_kind    = out_q.kind;
  assign out_o.body_byte   = out_q.body_byte;
  assign out_o.last        = out_q.last;
  assign out_o.status_code = out_q.status_code;
  assign out_o.body_length = out_q.body_length;

  // last goes with every kind except a plain body byte
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.last == (out_q.kind != KIND_BYTE)))
    else $error("last flag does not match result kind");
  // completions and errors carry no byte
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.kind == KIND_DONE || out_q.kind == KIND_ERR))
      |-> (out_q.body_byte == 8'd0))
    else $error("byte on completion or error");
  // an empty input register always takes a word
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_i.ready) else $error("empty input register not ready");

endmodule
`default_nettype wire

### sim/http_response_body_deframer_top_tb.sv
// http_response_body_deframer_top_tb: self-checking bench for the response body deframer
// depends on hrbd_pkg, hrbd_in_if, hrbd_out_if, http_response_body_deframer_top
`timescale 1ns / 1ps
module http_response_body_deframer_top_tb;
  import hrbd_pkg::*;

  localparam int unsigned MaxLine  = DefMaxLine;
  localparam int unsigned BufBytes = DefBufBytes;

  // one expected result word
  typedef struct packed {
    hrbd_kind_e  kind;
    logic [7:0]  body_byte;
    logic        last;
    logic [15:0] status_code;
    logic [16:0] body_length;
  } deframe_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  hrbd_in_if  in_ch();
  hrbd_out_if out_ch();

  http_response_body_deframer_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // idle and stall rates in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;

  deframe_word_t expected_words[$];

  // predictor state
  hrbd_phase_e ph;
  logic [1:0]  crlf_st;
  logic [15:0] line_len;
  logic [4:0]  stat_pos, enc_pos, len_pos;
  logic        got_stat, got_enc, is_chunked, got_len, search_off;
  logic [31:0] stat_val, clen, chunk_left;
  logic [3:0]  hex_cnt;
  logic        head_only;
  logic [16:0] taken, delivered;

  function automatic void clear_parse();
    ph = PH_HEADER; crlf_st = '0; line_len = '0;
    stat_pos = '0; enc_pos = '0; len_pos = '0;
    got_stat = 0; got_enc = 0; is_chunked = 0; got_len = 0; search_off = 0;
    stat_val = '0; clen = '0; chunk_left = '0; hex_cnt = '0;
    head_only = 0; taken = '0; delivered = '0;
  endfunction

  function automatic void push_word(hrbd_kind_e k, logic [7:0] b, logic l);
    deframe_word_t w;
    w.kind = k; w.body_byte = b; w.last = l;
    w.status_code = stat_val[15:0]; w.body_length = delivered;
    expected_words.push_back(w);
  endfunction

  function automatic logic ws_char(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic logic dig_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int hex_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  // line end: decide which fields matched on this line
  function automatic void close_line();
    if (32'(line_len) + 1 >= MaxLine) begin
      search_off = 1;
      if (!got_stat) stat_val = 0;
      if (!got_len) clen = 0;
      return;
    end
    if (!got_stat) begin
      if (stat_pos == 9 || stat_pos == 10) got_stat = 1;
      else stat_val = 0;
    end
    if (!got_enc) begin
      if (enc_pos == 25 || enc_pos == 27) begin
        got_enc = 1; is_chunked = 1;
      end else if ((enc_pos >= 19 && enc_pos <= 24) || enc_pos == 26) got_enc = 1;
    end
    if (!got_len) begin
      if (len_pos == 16 || len_pos == 17) got_len = 1;
      else clen = 0;
    end
  endfunction

  function automatic void header_scan(logic [7:0] b);
    string sp = "HTTP/1.1";
    string se = "Transfer-Encoding:";
    string sc = "chunked";
    string sl = "Content-Length:";
    if (b == ChLf) begin
      close_line();
      stat_pos = 0; enc_pos = 0; len_pos = 0; line_len = 0;
      return;
    end
    if (line_len == 0 && b == ChCr) begin
      search_off = 1;
      return;
    end
    if (!got_stat) begin
      if (stat_pos < 8) stat_pos = (b == sp[stat_pos]) ? stat_pos + 1 : 15;
      else if (stat_pos == 8) begin
        if (dig_char(b)) begin
          stat_val = b - "0"; stat_pos = 9;
        end else if (!ws_char(b)) stat_pos = 15;
      end else if (stat_pos == 9) begin
        if (dig_char(b)) begin
          stat_val = stat_val * 10 + (b - "0");
          if (stat_val > 32'hFFFF) stat_val = 32'hFFFF;
        end else stat_pos = 10;
      end
    end
    if (!got_enc) begin
      if (enc_pos < 18) enc_pos = (b == se[enc_pos]) ? enc_pos + 1 : 31;
      else if (enc_pos == 18) begin
        if (b == "c") enc_pos = 19;
        else if (!ws_char(b)) enc_pos = 26;
      end else if (enc_pos >= 19 && enc_pos <= 24) begin
        enc_pos = (b == sc[enc_pos - 18]) ? enc_pos + 1 : 26;
      end else if (enc_pos == 25) enc_pos = ws_char(b) ? 27 : 26;
    end
    if (!got_len) begin
      if (len_pos < 15) len_pos = (b == sl[len_pos]) ? len_pos + 1 : 31;
      else if (len_pos == 15) begin
        if (dig_char(b)) begin
          clen = b - "0"; len_pos = 16;
        end else if (!ws_char(b)) len_pos = 31;
      end else if (len_pos == 16) begin
        if (dig_char(b)) begin
          if (clen > (32'hFFFF_FFFF - (b - "0")) / 10) clen = 32'hFFFF_FFFF;
          else clen = clen * 10 + (b - "0");
        end else len_pos = 17;
      end
    end
    if (line_len < 16'hFFFF) line_len++;
  endfunction

  // predict the result of one accepted word
  function automatic void predict_word(logic start, logic [7:0] b, logic head);
    int h;
    if (start) begin
      clear_parse();
      head_only = head;
      return;
    end
    if (32'(taken) >= BufBytes) begin
      push_word(KIND_ERR, 8'h00, 1); clear_parse(); return;
    end
    taken++;
    case (ph)
      PH_HEADER: begin
        if (!search_off) header_scan(b);
        if (b == ChLf && crlf_st == 3) begin
          if (!got_stat) begin
            push_word(KIND_ERR, 8'h00, 1); clear_parse();
          end else if (head_only || (!is_chunked && clen == 0)) begin
            push_word(KIND_DONE, 8'h00, 1); clear_parse();
          end else if (is_chunked) begin
            ph = PH_SIZE; chunk_left = 0; hex_cnt = 0;
          end else ph = PH_FIXED;
          return;
        end
        if (b == (crlf_st[0] ? ChLf : ChCr)) crlf_st = crlf_st + 1;
        else crlf_st = (b == ChCr) ? 2'd1 : 2'd0;
      end
      PH_FIXED: begin
        delivered++;
        if (32'(delivered) >= clen) begin
          push_word(KIND_FINAL, b, 1); clear_parse();
        end else push_word(KIND_BYTE, b, 0);
      end
      PH_SIZE: begin
        h = hex_of(b);
        if (h >= 0 && hex_cnt < 8) begin
          chunk_left = (chunk_left << 4) | h; hex_cnt++;
        end else if (h < 0 && b == ChCr && hex_cnt != 0) ph = PH_SIZE_LF;
        else begin
          push_word(KIND_ERR, 8'h00, 1); clear_parse();
        end
      end
      PH_SIZE_LF: begin
        if (b != ChLf) begin
          push_word(KIND_ERR, 8'h00, 1); clear_parse();
        end else ph = (chunk_left == 0) ? PH_END1 : PH_DATA;
      end
      PH_DATA: begin
        delivered++; chunk_left--;
        if (chunk_left == 0) ph = PH_TRAIL1;
        push_word(KIND_BYTE, b, 0);
      end
      PH_TRAIL1: ph = PH_TRAIL2;
      PH_TRAIL2: begin
        ph = PH_SIZE; chunk_left = 0; hex_cnt = 0;
      end
      PH_END1: ph = PH_END2;
      default: begin
        push_word(KIND_DONE, 8'h00, 1); clear_parse();
      end
    endcase
  endfunction

  // drive one word and wait for its handshake
  task automatic send_word(logic start, logic [7:0] b, logic head);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= start;
    in_ch.data_byte <= b;
    in_ch.no_body <= head;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
    predict_word(start, b, head);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    deframe_word_t w;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word kind %0d", out_ch.out_kind);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          if (out_ch.out_kind != w.kind) begin
            $error("out_kind exp %0d got %0d", w.kind, out_ch.out_kind); fail_count++;
          end
          if (out_ch.body_byte != w.body_byte) begin
            $error("body_byte exp %0h got %0h", w.body_byte, out_ch.body_byte);
            fail_count++;
          end
          if (out_ch.last != w.last) begin
            $error("last exp %0d got %0d", w.last, out_ch.last); fail_count++;
          end
          if (out_ch.status_code != w.status_code) begin
            $error("status_code exp %0d got %0d", w.status_code, out_ch.status_code);
            fail_count++;
          end
          if (out_ch.body_length != w.body_length) begin
            $error("body_length exp %0d got %0d", w.body_length, out_ch.body_length);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic string rand_hdr_line();
    case ($urandom_range(5))
      0: return "Server: x\r\n";
      1: return "Content-Length: -3\r\n";
      2: return "Transfer-Encoding: gzip\r\n";
      3: return "X-A:\t1\r\n";
      4: return "HTTP/1.0 200\r\n";
      default: return "Connection: close\r\n";
    endcase
  endfunction

  // one response with random content and optional damage, or a run of noise bytes
  task automatic send_random_response();
    int mode = $urandom_range(9);
    int n;
    send_word(1'b1, 8'h00, $urandom_range(9) == 0);
    send_text($sformatf("HTTP/1.1 %0d OK\r\n", $urandom_range(100, 599)));
    if ($urandom_range(1)) send_text(rand_hdr_line());
    if (mode < 5) begin
      n = $urandom_range(0, 12);
      send_text($sformatf("Content-Length: %0d\r\n\r\n", n));
      repeat (n) send_word(1'b0, 8'($urandom), 1'b0);
    end else if (mode < 9) begin
      send_text("Transfer-Encoding: chunked\r\n\r\n");
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(1, 10);
        send_text($urandom_range(1) ? $sformatf("%0x\r\n", n) : $sformatf("%0X\r\n", n));
        repeat (n) send_word(1'b0, 8'($urandom), 1'b0);
        send_word(1'b0, 8'($urandom), 1'b0);
        send_word(1'b0, 8'($urandom), 1'b0);
      end
      if ($urandom_range(4) == 0) send_word(1'b0, 8'($urandom), 1'b0);
      else send_text("0\r\n\r\n");
    end else begin
      // noise: random bytes with bias toward line breaks
      repeat ($urandom_range(3, 20))
        send_word(1'b0, $urandom_range(3) == 0 ? ChLf : 8'($urandom), 1'b0);
    end
  endtask

  task automatic test_fixed_length();
    send_word(1'b1, 8'h00, 1'b0);
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_word(1'b0, 8'hA5, 1'b0);
  endtask

  task automatic test_chunked();
    send_word(1'b1, 8'h00, 1'b0);
    send_text("HTTP/1.1 99999\r\nTransfer-Encoding: \tchunked \r\n\r\n2\r\n");
    send_word(1'b0, 8'h5A, 1'b0);
    send_word(1'b0, 8'hC3, 1'b0);
    send_text("\r\n0\r\n\r\n");
  endtask

  task automatic test_header_cases();
    // head reply, missing status, no length, chunk size errors, oversized length
    send_word(1'b1, 8'h00, 1'b1);
    send_text("HTTP/1.1 204\r\nContent-Length: 9\r\n\r\n");
    send_word(1'b1, 8'h00, 1'b0);
    send_text("Content-Length: 4\r\n\r\n");
    send_text("HTTP/1.1 301\r\n\r\n");
    send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n\r\n");
    send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n123456789\r\n");
    send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\n1\rx");
    send_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\n");
    send_word(1'b1, 8'h00, 1'b0);
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, int unsigned words);
    int unsigned first_cnt = words_sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    do begin
      send_random_response();
    end while (words_sent - first_cnt < words);
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.no_body = 1'b0;
    out_ch.ready = 1'b0;
    clear_parse();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fixed_length();
    test_chunked();
    test_header_cases();
    wait_drained();
    test_random(0, 0, 20);
    test_random(45, 0, 20);
    test_random(0, 45, 20);
    test_random(32, 32, 20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
